/* design/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key/value cache
// default sizes, capacity register layout and the per-cell control word
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int SLOTS_DEFAULT      = 16;
	localparam int KEY_SPACE_DEFAULT  = 1024;
	localparam int VALUE_BITS_DEFAULT = 64;

	// capacity register
	localparam int          CAP_W     = 5;
	localparam logic [4:0]  CAP_RESET = 5'd16;

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// control word sent to each cell of the recency chain
	typedef struct packed {
		logic clear;  // drop the entry (cache emptied)
		logic shift;  // take the neighbor's entry this cycle
	} lkvc_cell_ctrl_t;

endpackage

/* design/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache: least-recently-used key/value cache
// entries sit in a chain of cells ordered by recency, cell 0 most recent;
// a hit or an insert moves the entry to cell 0 while older cells shift down
// ----------------------------------------------------------------------------
// sequence: the result word is registered after the search and chain update
//   steps, and later while the result register is stalled
// requests: a new word is accepted only after the previous one has passed
//   accept, search and chain update, set by the search-then-shift sequence of the single cell chain
// reset: cache empty, capacity 16, no result pending; no clearing pass
// ----------------------------------------------------------------------------
module lru_key_value_cache
	import lkvc_pkg::*;
#(
	parameter int SLOTS      = SLOTS_DEFAULT,
	parameter int KEY_SPACE  = KEY_SPACE_DEFAULT,
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	// configuration
	input  logic                                       cfg_we,
	input  logic [CAP_W-1:0]                           cfg_wdata,
	// request channel
	input  logic                                       req_valid,
	output logic                                       req_stall,
	input  logic                                       operation,
	input  logic [(KEY_SPACE > 1 ? $clog2(KEY_SPACE) : 1)-1:0] key,
	input  logic [VALUE_BITS-1:0]                      write_value,
	// response channel
	output logic                                       rsp_valid,
	input  logic                                       rsp_stall,
	output logic                                       found,
	output logic [VALUE_BITS-1:0]                      read_value,
	output logic                                       evicted,
	output logic [(KEY_SPACE > 1 ? $clog2(KEY_SPACE) : 1)-1:0] evicted_key
);

	localparam int KEY_W = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	state_t state_q;

	// capacity and fill level
	logic [CAP_W-1:0] cap_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] eff_cap;

	// captured request word
	logic                  op_q;
	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] wv_q;
	logic                  in_range_q;

	// search results
	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_BITS-1:0] hit_value_q;
	logic                  full_q;
	logic [KEY_W-1:0]      lru_key_q;

	// cell chain, index 0 is the head input
	logic [KEY_W-1:0]      chain_key   [SLOTS+1];
	logic [VALUE_BITS-1:0] chain_value [SLOTS+1];
	logic                  chain_valid [SLOTS+1];
	logic [SLOTS-1:0]      cell_valid;
	logic [SLOTS-1:0]      match_vec;
	lkvc_cell_ctrl_t       cell_ctrl   [SLOTS];

	logic                  out_free;
	logic                  do_update;
	logic                  commit;
	logic [IDX_W-1:0]      limit;
	logic                  any_match;
	logic [IDX_W-1:0]      match_idx;
	logic [VALUE_BITS-1:0] match_value;
	logic [KEY_W-1:0]      lru_key;

	// clamp capacity into 1..SLOTS
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = OCC_W'(1);
		end else if (int'(cap_q) > SLOTS) begin
			eff_cap = OCC_W'(SLOTS);
		end else begin
			eff_cap = OCC_W'(cap_q);
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid || !rsp_stall;

	// entry moves to the head on any hit, or on an in-range put miss
	assign do_update = in_range_q && (hit_q || (op_q == OP_PUT));
	assign commit    = (state_q == ST_UPDATE) && out_free;

	// deepest cell that shifts: the hit cell, the lru cell when full,
	// else the first empty cell
	always_comb begin
		if (hit_q) begin
			limit = hit_idx_q;
		end else if (full_q) begin
			limit = IDX_W'(occ_q - OCC_W'(1));
		end else begin
			limit = IDX_W'(occ_q);
		end
	end

	// head of the chain: the entry that becomes most recent
	assign chain_key[0]   = key_q;
	assign chain_value[0] = (op_q == OP_PUT) ? wv_q : hit_value_q;
	assign chain_valid[0] = 1'b1;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			always_comb begin
				cell_ctrl[gi].clear = cfg_we;
				cell_ctrl[gi].shift = commit && do_update && (gi <= int'(limit));
			end

			lkvc_cell #(
				.KEY_W      (KEY_W),
				.VALUE_BITS (VALUE_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (cell_ctrl[gi]),
				.prev_key   (chain_key[gi]),
				.prev_value (chain_value[gi]),
				.prev_valid (chain_valid[gi]),
				.cmp_key    (key_q),
				.key        (chain_key[gi+1]),
				.value      (chain_value[gi+1]),
				.valid      (chain_valid[gi+1]),
				.match      (match_vec[gi])
			);

			assign cell_valid[gi] = chain_valid[gi+1];
		end
	endgenerate

	// and-or reduction of the match and lru cells; keys are unique so at
	// most one cell matches
	always_comb begin
		any_match   = 1'b0;
		match_idx   = '0;
		match_value = '0;
		lru_key     = '0;
		for (int i = 0; i < SLOTS; i++) begin
			any_match   = any_match | match_vec[i];
			match_idx   = match_idx | (match_vec[i] ? IDX_W'(i) : '0);
			match_value = match_value | (match_vec[i] ? chain_value[i+1] : '0);
			if (cell_valid[i] && ((i == SLOTS - 1) || !chain_valid[i+2 > SLOTS ? SLOTS : i+2]))
			begin
				lru_key = lru_key | chain_key[i+1];
			end
		end
	end

	// sequencer, capacity, fill level and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cap_q     <= CAP_RESET;
			occ_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			if (cfg_we) begin
				cap_q <= cfg_wdata;
				occ_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free) begin
						state_q   <= ST_IDLE;
						rsp_valid <= 1'b1;
						if (do_update && !hit_q && !full_q) begin
							occ_q <= occ_q + OCC_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q       <= operation;
			key_q      <= key;
			wv_q       <= write_value;
			in_range_q <= ({1'b0, key} < (KEY_W+1)'(KEY_SPACE));
		end
		if (state_q == ST_SEARCH) begin
			hit_q       <= any_match && in_range_q;
			hit_idx_q   <= match_idx;
			hit_value_q <= match_value;
			full_q      <= (occ_q >= eff_cap);
			lru_key_q   <= lru_key;
		end
		if (commit) begin
			found       <= hit_q;
			read_value  <= (hit_q && op_q == OP_GET) ? hit_value_q : '0;
			evicted     <= in_range_q && !hit_q && (op_q == OP_PUT) && full_q;
			evicted_key <= (in_range_q && !hit_q && (op_q == OP_PUT) && full_q)
				? lru_key_q : '0;
		end
	end

	// live entries fill the chain from the head, one per counted slot
	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == int'(occ_q))
		else $error("cell valid bits disagree with fill level");

	// fill level never passes the clamped capacity
	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= eff_cap)
		else $error("fill level above capacity");

	// a key lives in at most one cell
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> $onehot0(match_vec))
		else $error("duplicate key in chain");

	// a result word appears only out of the update step
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_UPDATE))
		else $error("result word without update");

endmodule

/* design/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell: one entry of the recency chain
// holds a key, a data word and a valid bit; compares against the lookup key
// and takes its newer neighbor's entry when told to shift
// ----------------------------------------------------------------------------
module lkvc_cell
	import lkvc_pkg::*;
#(
	parameter int KEY_W      = 10,
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkvc_cell_ctrl_t       ctrl,
	input  logic [KEY_W-1:0]      prev_key,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic                  prev_valid,
	input  logic [KEY_W-1:0]      cmp_key,
	output logic [KEY_W-1:0]      key,
	output logic [VALUE_BITS-1:0] value,
	output logic                  valid,
	output logic                  match
);

	logic [KEY_W-1:0]      key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign valid = valid_q;
	assign match = valid_q && (key_q == cmp_key);

endmodule
